// ----- sv/u8d_pkg.sv -----
// u8d_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies.
package u8d_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned CpW     = 21;
   localparam int unsigned StatusW = 3;

   // result status codes
   localparam logic [StatusW-1:0] ST_OK       = 3'd0;
   localparam logic [StatusW-1:0] ST_END      = 3'd1;
   localparam logic [StatusW-1:0] ST_OVERLONG = 3'd2;
   localparam logic [StatusW-1:0] ST_TRUNC    = 3'd3;
   localparam logic [StatusW-1:0] ST_BADLEAD  = 3'd4;

   // smallest legal value for each sequence length
   localparam logic [CpW-1:0] FLOOR_2 = 21'h00080;
   localparam logic [CpW-1:0] FLOOR_3 = 21'h00800;
   localparam logic [CpW-1:0] FLOOR_4 = 21'h10000;

   localparam logic [2:0] LEN_2 = 3'd2;
   localparam logic [2:0] LEN_3 = 3'd3;

   typedef struct packed {
      logic [1:0]     bytes_left;
      logic [2:0]     seq_length;
      logic [CpW-1:0] accum;
   } u8d_state_type;

   typedef struct packed {
      logic               valid;
      logic [CpW-1:0]     code_point;
      logic [StatusW-1:0] status;
   } u8d_result_type;

endpackage

// ----- sv/utf8_stream_decoder.sv -----
// utf8_stream_decoder: streaming UTF-8 decoder, one byte word in, at most one
// code point word out. Each result is written to the result register when its final byte is accepted.
// Throughput 1 byte per cycle; a new byte is taken while the result register
// is empty or its word is taken in the same cycle.
// Reset (synchronous, active high) closes any open sequence, clears the
// accumulator and empties the result register.
module utf8_stream_decoder import u8d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ByteW-1:0]   req_in_byte,
   input  logic               req_end_of_string,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CpW-1:0]     rsp_code_point,
   output logic [StatusW-1:0] rsp_status
);

   // sequence state: bytes still expected, length, gathered bits
   u8d_state_type  state_ff, state_in;
   u8d_state_type  step_nxt;
   u8d_result_type step_res;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CpW-1:0]     cp_ff, cp_in;
   logic [StatusW-1:0] status_ff, status_in;

   logic take;

   u8d_step u_step (
      .cur     (state_ff),
      .in_byte (req_in_byte),
      .last    (req_end_of_string),
      .nxt     (step_nxt),
      .res     (step_res)
   );

   // Accept whenever the result slot is free or drains this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cp_in        = cp_ff;
      status_in    = status_ff;
      if (take) begin
         state_in = step_nxt;
         if (step_res.valid) begin
            rsp_valid_in = 1'b1;
            cp_in        = step_res.code_point;
            status_in    = step_res.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cp_ff     <= cp_in;
      status_ff <= status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = cp_ff;
   assign rsp_status     = status_ff;

`ifndef ASSERT_OFF
   // any non-ok status carries a zero code point
   a_err_cp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_code_point == '0)
      else $error("error status with nonzero code point");

   // an open sequence always has a length, an idle decoder none
   a_len_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_left == 2'd0) == (state_ff.seq_length == 3'd0))
      else $error("sequence length and bytes left disagree");

   // the end mark always leaves the decoder idle
   a_end_idles: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_string) |=> state_ff.bytes_left == 2'd0)
      else $error("sequence still open after end mark");

   // a word is never accepted while the result slot is held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("byte accepted over a stalled result");
`endif

endmodule

// ----- sv/u8d_step.sv -----
// u8d_step: combinational next-state and result logic for one byte.
// Depends on u8d_pkg.
module u8d_step import u8d_pkg::*; (
   input  u8d_state_type      cur,
   input  logic [ByteW-1:0]   in_byte,
   input  logic               last,
   output u8d_state_type      nxt,
   output u8d_result_type     res
);

   logic [CpW-1:0] acc_shift;
   logic [1:0]     left_dec;
   logic [CpW-1:0] floor_val;

   assign acc_shift = {cur.accum[CpW-7:0], in_byte[5:0]};
   assign left_dec  = cur.bytes_left - 2'd1;

   always_comb begin
      case (cur.seq_length)
         LEN_2:   floor_val = FLOOR_2;
         LEN_3:   floor_val = FLOOR_3;
         default: floor_val = FLOOR_4;
      endcase
   end

   always_comb begin
      nxt = cur;
      res = '{valid: 1'b0, code_point: '0, status: ST_OK};
      if (cur.bytes_left == 2'd0) begin
         if (in_byte == 8'h00) begin
            res = '{valid: 1'b1, code_point: '0, status: ST_END};
         end else if (in_byte inside {[8'h01:8'hBF], 8'hFE, 8'hFF}) begin
            res = '{valid: 1'b1, code_point: {13'd0, in_byte}, status: ST_OK};
         end else if (in_byte inside {[8'hF8:8'hFD]}) begin
            res = '{valid: 1'b1, code_point: '0, status: ST_BADLEAD};
         end else if (last) begin
            nxt = '0;
            res = '{valid: 1'b1, code_point: '0, status: ST_TRUNC};
         end else if (in_byte inside {[8'hC0:8'hDF]}) begin
            nxt = '{bytes_left: 2'd1, seq_length: 3'd2, accum: {16'd0, in_byte[4:0]}};
         end else if (in_byte inside {[8'hE0:8'hEF]}) begin
            nxt = '{bytes_left: 2'd2, seq_length: 3'd3, accum: {17'd0, in_byte[3:0]}};
         end else begin
            nxt = '{bytes_left: 2'd3, seq_length: 3'd4, accum: {18'd0, in_byte[2:0]}};
         end
      end else if (left_dec != 2'd0) begin
         // middle byte
         if (last) begin
            nxt = '0;
            res = '{valid: 1'b1, code_point: '0, status: ST_TRUNC};
         end else begin
            nxt.bytes_left = left_dec;
            nxt.accum      = acc_shift;
         end
      end else begin
         // final byte: overlong check
         nxt = '0;
         if (acc_shift < floor_val) begin
            res = '{valid: 1'b1, code_point: '0, status: ST_OVERLONG};
         end else begin
            res = '{valid: 1'b1, code_point: acc_shift, status: ST_OK};
         end
      end
   end

endmodule
